// ===== hw/rtl/gpm_pkg.sv =====
package gpm_pkg;

    // request commands
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_NEXT  = 1'b1;

    // record kinds
    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_VERTEX = 2'd1;
    localparam logic [1:0] KIND_QUAD   = 2'd2;
    localparam logic [1:0] KIND_DONE   = 2'd3;

    // fixed point format
    localparam int          FRAC_BITS = 16;
    localparam logic [31:0] ONE_Q16   = 32'h0001_0000;

    // controller to datapath commands
    typedef struct packed {
        logic       load_start;
        logic       hdr_mul;
        logic       div_start;
        logic       div_on_z;
        logic       quad_mul;
        logic       emit;
        logic [1:0] kind;
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic div_done;
        logic vert_last;
        logic quad_last;
    } dp_stat_t;

endpackage

// ===== hw/rtl/gpm_req_if.sv =====
interface gpm_req_if;
    logic               valid;
    logic               ready;
    logic               command;
    logic signed [31:0] subdivisions;

    modport source (output valid, output command, output subdivisions, input ready);
    modport sink   (input valid, input command, input subdivisions, output ready);
endinterface

// ===== hw/rtl/gpm_rec_if.sv =====
interface gpm_rec_if;
    logic        valid;
    logic        ready;
    logic [1:0]  record_kind;
    logic        last_record;
    logic [31:0] word0;
    logic [31:0] word1;
    logic [31:0] word2;
    logic [31:0] word3;
    logic [31:0] word4;
    logic [31:0] word5;

    modport source (output valid, output record_kind, output last_record,
                    output word0, output word1, output word2, output word3,
                    output word4, output word5, input ready);
    modport sink   (input valid, input record_kind, input last_record,
                    input word0, input word1, input word2, input word3,
                    input word4, input word5, output ready);
endinterface

// ===== hw/rtl/gpm_datapath.sv =====
module gpm_datapath
    import gpm_pkg::*;
#(
    parameter int MAX_SUBDIV = 1023
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  dp_cmd_t            cmd,
    output dp_stat_t           stat,
    input  logic signed [31:0] subdivisions,
    output logic [1:0]         record_kind,
    output logic               last_record,
    output logic [31:0]        word0,
    output logic [31:0]        word1,
    output logic [31:0]        word2,
    output logic [31:0]        word3,
    output logic [31:0]        word4,
    output logic [31:0]        word5
);

    localparam int             SW    = $clog2(MAX_SUBDIV + 1);
    localparam int             CW    = $clog2(FRAC_BITS);
    localparam logic [SW-1:0]  S_MAX = SW'(MAX_SUBDIV);

    // mesh state
    logic [SW-1:0] s_reg;
    logic [SW-1:0] col_reg;
    logic [SW-1:0] row_reg;

    // products
    logic [31:0]   prod_reg;
    logic [31:0]   sq_reg;

    // divider
    logic          div_busy_reg;
    logic          div_done_reg;
    logic [CW-1:0] div_cnt_reg;
    logic [SW-1:0] rem_reg;
    logic          qint_reg;
    logic [FRAC_BITS-1:0] qfrac_reg;
    logic          neg_reg;
    logic          z_target_reg;
    logic [31:0]   x_reg;
    logic [31:0]   z_reg;

    // output record
    logic [1:0]    kind_reg;
    logic          last_reg;
    logic [31:0]   w0_reg;
    logic [31:0]   w1_reg;
    logic [31:0]   w2_reg;
    logic [31:0]   w3_reg;
    logic [31:0]   w4_reg;
    logic [31:0]   w5_reg;

    logic [31:0]   raw;
    logic [SW-1:0] s_clamped;
    logic          col_last_v;
    logic          row_last_v;
    logic          col_last_q;
    logic          row_last_q;
    logic [SW:0]   s_plus1;
    logic [SW:0]   mul_a;
    logic [2*SW+1:0] mul_p;
    logic [2*SW-1:0] sq_p;
    logic [SW-1:0] div_idx;
    logic [SW+1:0] diff;
    logic          diff_neg;
    logic [SW+1:0] mag_w;
    logic [SW-1:0] mag;
    logic          mag_full;
    logic [SW:0]   shifted;
    logic [SW:0]   shift_sub;
    logic          ge;
    logic [31:0]   quot;
    logic [31:0]   coord;
    logic [SW+1:0] off_bl;
    logic [SW+1:0] off_br;
    logic [SW:0]   off_tr;
    logic [31:0]   idx_tl;
    logic [31:0]   idx_tr;
    logic [31:0]   idx_bl;
    logic [31:0]   idx_br;

    // clamp the requested cell count
    assign raw = subdivisions;
    always_comb
    begin
        if (raw[31] || raw == 32'd0)
            s_clamped = SW'(1);
        else if (raw > 32'(MAX_SUBDIV))
            s_clamped = S_MAX;
        else
            s_clamped = raw[SW-1:0];
    end

    // end of row and end of mesh checks
    assign col_last_v = (col_reg == s_reg);
    assign row_last_v = (row_reg == s_reg);
    assign col_last_q = (({1'b0, col_reg} + (SW+1)'(1)) == {1'b0, s_reg});
    assign row_last_q = (({1'b0, row_reg} + (SW+1)'(1)) == {1'b0, s_reg});

    assign stat.vert_last = col_last_v && row_last_v;
    assign stat.quad_last = col_last_q && row_last_q;
    assign stat.div_done  = div_done_reg;

    // counters advance on each vertex and quad record emitted
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_reg   <= SW'(1);
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cmd.load_start)
        begin
            s_reg   <= s_clamped;
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cmd.emit && cmd.kind == KIND_VERTEX)
        begin
            if (col_last_v)
            begin
                col_reg <= '0;
                row_reg <= row_last_v ? '0 : row_reg + SW'(1);
            end
            else
                col_reg <= col_reg + SW'(1);
        end
        else if (cmd.emit && cmd.kind == KIND_QUAD)
        begin
            if (col_last_q)
            begin
                col_reg <= '0;
                row_reg <= row_last_q ? '0 : row_reg + SW'(1);
            end
            else
                col_reg <= col_reg + SW'(1);
        end
    end

    // shared multiplier: (s+1)^2 for the header, row*(s+1) for quads
    assign s_plus1 = {1'b0, s_reg} + (SW+1)'(1);
    assign mul_a   = cmd.quad_mul ? {1'b0, row_reg} : s_plus1;
    assign mul_p   = mul_a * s_plus1;
    assign sq_p    = s_reg * s_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.hdr_mul || cmd.quad_mul)
            prod_reg <= 32'(mul_p);
        if (cmd.hdr_mul)
            sq_reg <= 32'(sq_p);
    end

    // divider operand: magnitude and sign of 2i - s
    assign div_idx  = cmd.div_on_z ? row_reg : col_reg;
    assign diff     = {1'b0, div_idx, 1'b0} - {2'b00, s_reg};
    assign diff_neg = diff[SW+1];
    assign mag_w    = diff_neg ? (~diff + (SW+2)'(1)) : diff;
    assign mag      = mag_w[SW-1:0];
    assign mag_full = (mag == s_reg);

    // restoring divide step, one fraction bit a cycle
    assign shifted   = {rem_reg, 1'b0};
    assign ge        = (shifted >= {1'b0, s_reg});
    assign shift_sub = shifted - {1'b0, s_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_busy_reg <= 1'b0;
            div_done_reg <= 1'b0;
            div_cnt_reg  <= '0;
        end
        else if (cmd.div_start)
        begin
            div_busy_reg <= 1'b1;
            div_done_reg <= 1'b0;
            div_cnt_reg  <= CW'(FRAC_BITS - 1);
        end
        else if (div_busy_reg)
        begin
            if (div_cnt_reg == '0)
            begin
                div_busy_reg <= 1'b0;
                div_done_reg <= 1'b1;
            end
            else
                div_cnt_reg <= div_cnt_reg - CW'(1);
        end
        else
            div_done_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            rem_reg      <= mag_full ? '0 : mag;
            qint_reg     <= mag_full;
            neg_reg      <= diff_neg;
            z_target_reg <= cmd.div_on_z;
        end
        else if (div_busy_reg)
        begin
            rem_reg   <= ge ? shift_sub[SW-1:0] : shifted[SW-1:0];
            qfrac_reg <= {qfrac_reg[FRAC_BITS-2:0], ge};
        end
    end

    // signed coordinate from the quotient
    assign quot  = 32'({qint_reg, qfrac_reg});
    assign coord = neg_reg ? (~quot + 32'd1) : quot;

    always_ff @(posedge clk)
    begin
        if (div_done_reg)
        begin
            if (z_target_reg)
                z_reg <= coord;
            else
                x_reg <= coord;
        end
    end

    // quad corner indices
    assign off_tr = {1'b0, col_reg} + (SW+1)'(1);
    assign off_bl = {2'b00, col_reg} + {2'b00, s_reg} + (SW+2)'(1);
    assign off_br = {2'b00, col_reg} + {2'b00, s_reg} + (SW+2)'(2);
    assign idx_tl = prod_reg + 32'(col_reg);
    assign idx_tr = prod_reg + 32'(off_tr);
    assign idx_bl = prod_reg + 32'(off_bl);
    assign idx_br = prod_reg + 32'(off_br);

    // output record register
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            kind_reg <= cmd.kind;
            last_reg <= (cmd.kind == KIND_QUAD) && stat.quad_last;
            case (cmd.kind)
                KIND_HEADER:
                begin
                    w0_reg <= prod_reg;
                    w1_reg <= (sq_reg << 2) + (sq_reg << 1);
                    w2_reg <= '0;
                    w3_reg <= '0;
                    w4_reg <= '0;
                    w5_reg <= '0;
                end
                KIND_VERTEX:
                begin
                    w0_reg <= x_reg;
                    w1_reg <= '0;
                    w2_reg <= z_reg;
                    w3_reg <= '0;
                    w4_reg <= ONE_Q16;
                    w5_reg <= '0;
                end
                KIND_QUAD:
                begin
                    w0_reg <= idx_tl;
                    w1_reg <= idx_bl;
                    w2_reg <= idx_tr;
                    w3_reg <= idx_tr;
                    w4_reg <= idx_bl;
                    w5_reg <= idx_br;
                end
                default:
                begin
                    w0_reg <= '0;
                    w1_reg <= '0;
                    w2_reg <= '0;
                    w3_reg <= '0;
                    w4_reg <= '0;
                    w5_reg <= '0;
                end
            endcase
        end
    end

    assign record_kind = kind_reg;
    assign last_record = last_reg;
    assign word0       = w0_reg;
    assign word1       = w1_reg;
    assign word2       = w2_reg;
    assign word3       = w3_reg;
    assign word4       = w4_reg;
    assign word5       = w5_reg;

endmodule

// ===== hw/rtl/gpm_ctrl.sv =====
module gpm_ctrl
    import gpm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     in_command,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    output dp_cmd_t  cmd,
    input  dp_stat_t stat
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_HDR  = 3'd1;
    localparam logic [2:0] ST_DIVX = 3'd2;
    localparam logic [2:0] ST_DIVZ = 3'd3;
    localparam logic [2:0] ST_QUAD = 3'd4;
    localparam logic [2:0] ST_EMIT = 3'd5;

    localparam logic [1:0] PH_DONE = 2'd0;
    localparam logic [1:0] PH_VERT = 2'd1;
    localparam logic [1:0] PH_QUAD = 2'd2;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic [1:0] phase_reg;
    logic [1:0] phase_next;
    logic [1:0] kind_reg;
    logic [1:0] kind_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == ST_IDLE);

    // sequencing of one request
    always_comb
    begin
        cmd        = '0;
        cmd.kind   = kind_reg;
        state_next = state_reg;
        phase_next = phase_reg;
        kind_next  = kind_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_command == CMD_START)
                    begin
                        cmd.load_start = 1'b1;
                        phase_next     = PH_VERT;
                        kind_next      = KIND_HEADER;
                        state_next     = ST_HDR;
                    end
                    else
                    begin
                        case (phase_reg)
                            PH_VERT:
                            begin
                                cmd.div_start = 1'b1;
                                kind_next     = KIND_VERTEX;
                                state_next    = ST_DIVX;
                            end
                            PH_QUAD:
                            begin
                                kind_next  = KIND_QUAD;
                                state_next = ST_QUAD;
                            end
                            default:
                            begin
                                kind_next  = KIND_DONE;
                                state_next = ST_EMIT;
                            end
                        endcase
                    end
                end
            end
            ST_HDR:
            begin
                cmd.hdr_mul = 1'b1;
                state_next  = ST_EMIT;
            end
            ST_DIVX:
            begin
                if (stat.div_done)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_on_z  = 1'b1;
                    state_next    = ST_DIVZ;
                end
            end
            ST_DIVZ:
            begin
                if (stat.div_done)
                    state_next = ST_EMIT;
            end
            ST_QUAD:
            begin
                cmd.quad_mul = 1'b1;
                state_next   = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                    if (kind_reg == KIND_VERTEX && stat.vert_last)
                        phase_next = PH_QUAD;
                    else if (kind_reg == KIND_QUAD && stat.quad_last)
                        phase_next = PH_DONE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output valid flag
    always_comb
    begin
        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_DONE;
            kind_reg      <= KIND_DONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            kind_reg      <= kind_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== hw/rtl/grid_plane_mesh_generator.sv =====
// channel | dir | payload                                         | request
// --------+-----+-------------------------------------------------+---------------------
// req     | in  | command, subdivisions                           | start or fetch
// rec     | out | record_kind, last_record, word0..word5          | one mesh record
//
// a vertex request runs two 16-step restoring divisions of 2i-s by the cell count back
// to back on one shared divider unit. a quad passes its multiply state (one registered
// multiply) and a start the header multiply state before emit; a done goes straight to emit.
// reset puts the block idle with no mesh in progress; fetches then return done.
// the result register lets a new request be taken while the last record waits;
// a stalled output keeps the controller in its emit state until it drains.
module grid_plane_mesh_generator
    import gpm_pkg::*;
#(
    parameter int MAX_SUBDIV = 1023
)
(
    input  logic      clk,
    input  logic      rst_n,
    gpm_req_if.sink   req,
    gpm_rec_if.source rec
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // request sequencing
    gpm_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (req.valid),
        .in_command (req.command),
        .in_ready   (req.ready),
        .out_valid  (rec.valid),
        .out_ready  (rec.ready),
        .cmd        (cmd),
        .stat       (stat)
    );

    // counters, divider, multiplier and record register
    gpm_datapath #(
        .MAX_SUBDIV (MAX_SUBDIV)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .subdivisions (req.subdivisions),
        .record_kind  (rec.record_kind),
        .last_record  (rec.last_record),
        .word0        (rec.word0),
        .word1        (rec.word1),
        .word2        (rec.word2),
        .word3        (rec.word3),
        .word4        (rec.word4),
        .word5        (rec.word5)
    );

endmodule
